@@ rtl/core/u8d_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

    // Field widths
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;

    // Byte class masks and tags
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_TAG   = 8'h80;
    localparam logic [BYTE_W-1:0] ASCII_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_TAG  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_TAG  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_TAG  = 8'hF0;

    // Result queue geometry
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = 2;
    localparam int unsigned QCNT_W = 3;

    typedef enum logic [2:0] {
        LEAD_ASCII,
        LEAD_TWO,
        LEAD_THREE,
        LEAD_FOUR,
        LEAD_BAD
    } lead_t;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_value;
        logic              string_end;
    } in_item_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            error;
        logic            last_result;
    } out_item_t;

    // Results raised by one byte, in order
    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } res_pair_t;

    // Classify a byte at a lead position
    function automatic lead_t lead_class(input logic [BYTE_W-1:0] b);
        lead_t cls;
        if ((b & ASCII_MASK) == '0) begin
            cls = LEAD_ASCII;
        end
        else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
            cls = LEAD_TWO;
        end
        else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
            cls = LEAD_THREE;
        end
        else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
            cls = LEAD_FOUR;
        end
        else begin
            cls = LEAD_BAD;
        end
        return cls;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/u8d_stream_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface u8d_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/core/u8d_decode.sv @@
`timescale 1ns / 1ps
`default_nettype none

module u8d_decode (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  u8d_pkg::in_item_t  in_item,
    output u8d_pkg::res_pair_t res
);
    import u8d_pkg::*;

    logic [1:0]      rem_reg, rem_next;
    logic [CP_W-1:0] pv_reg, pv_next;
    logic            skip_reg, skip_next;

    logic [BYTE_W-1:0] b;
    logic              str_end;
    logic              is_cont;
    lead_t             lead;
    logic [CP_W-1:0]   pv_shift;
    logic              do_lead;
    logic              pre_v, main_v, main_err, trunc_v;
    logic [CP_W-1:0]   main_cp;
    out_item_t         err_item, main_item;

    assign b       = in_item.byte_value;
    assign str_end = in_item.string_end;
    assign is_cont = (b & CONT_MASK) == CONT_TAG;
    assign lead    = lead_class(b);

    // Work out next state and the candidate results of this byte
    always_comb
    begin
        rem_next  = rem_reg;
        pv_next   = pv_reg;
        skip_next = skip_reg;
        pv_shift  = {pv_reg[CP_W-7:0], b[5:0]};
        do_lead   = 1'b0;
        pre_v     = 1'b0;
        main_v    = 1'b0;
        main_err  = 1'b0;
        main_cp   = '0;
        trunc_v   = 1'b0;

        if (rem_reg != 2'd0)
        begin
            if (is_cont)
            begin
                if (rem_reg == 2'd1)
                begin
                    main_v    = 1'b1;
                    main_cp   = pv_shift;
                    rem_next  = 2'd0;
                    pv_next   = '0;
                    skip_next = 1'b1;
                end
                else
                begin
                    rem_next = rem_reg - 2'd1;
                    pv_next  = pv_shift;
                    trunc_v  = str_end;
                end
            end
            else
            begin
                // broken sequence: flag it, then restart on this byte
                pre_v   = 1'b1;
                do_lead = 1'b1;
            end
        end
        else if (!(skip_reg && is_cont))
        begin
            do_lead = 1'b1;
        end

        if (do_lead)
        begin
            skip_next = 1'b0;
            rem_next  = 2'd0;
            pv_next   = '0;
            unique case (lead)
                LEAD_ASCII:
                begin
                    main_v  = 1'b1;
                    main_cp = {{(CP_W-BYTE_W){1'b0}}, b};
                end
                LEAD_TWO:
                begin
                    pv_next  = {{(CP_W-5){1'b0}}, b[4:0]};
                    rem_next = 2'd1;
                end
                LEAD_THREE:
                begin
                    pv_next  = {{(CP_W-4){1'b0}}, b[3:0]};
                    rem_next = 2'd2;
                end
                LEAD_FOUR:
                begin
                    pv_next  = {{(CP_W-3){1'b0}}, b[2:0]};
                    rem_next = 2'd3;
                end
                default:
                begin
                    main_v    = 1'b1;
                    main_err  = 1'b1;
                    skip_next = 1'b1;
                end
            endcase
            trunc_v = str_end && (rem_next != 2'd0);
        end

        // every string starts fresh
        if (str_end)
        begin
            rem_next  = 2'd0;
            pv_next   = '0;
            skip_next = 1'b0;
        end
    end

    // Pack the candidates into first and second result
    always_comb
    begin
        err_item.code_point   = '0;
        err_item.error        = 1'b1;
        err_item.last_result  = 1'b0;
        main_item.code_point  = main_err ? '0 : main_cp;
        main_item.error       = main_err;
        main_item.last_result = 1'b0;

        res.count = {1'b0, pre_v} + {1'b0, main_v} + {1'b0, trunc_v};

        priority if (pre_v)
        begin
            res.first = err_item;
        end
        else if (main_v)
        begin
            res.first = main_item;
        end
        else
        begin
            res.first = err_item;
        end

        if (pre_v && main_v)
        begin
            res.second = main_item;
        end
        else
        begin
            res.second = err_item;
        end

        res.first.last_result  = (res.count == 2'd1);
        res.second.last_result = 1'b1;
    end

    // Hold decoder state between bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= 2'd0;
            pv_reg   <= '0;
            skip_reg <= 1'b0;
        end
        else if (take)
        begin
            rem_reg  <= rem_next;
            pv_reg   <= pv_next;
            skip_reg <= skip_next;
        end
    end

    a_fresh_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (take && str_end) |=> (rem_reg == 2'd0 && skip_reg == 1'b0 && pv_reg == '0))
        else $error("decoder state not cleared after string end");

    a_err_zero_cp: assert property (@(posedge clk) disable iff (!rst_n)
        (res.count != 2'd0 && res.first.error) |-> (res.first.code_point == '0))
        else $error("error result carries a code point");

    a_no_pending_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg != 2'd0) |-> !skip_reg)
        else $error("skip set inside a sequence");

    a_max_two: assert property (@(posedge clk) disable iff (!rst_n)
        res.count != 2'd3)
        else $error("more than two results for one byte");

endmodule

`default_nettype wire

@@ rtl/core/u8d_out_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module u8d_out_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  u8d_pkg::res_pair_t res,
    output logic               room,
    u8d_stream_if.source       out_ch
);
    import u8d_pkg::*;

    out_item_t         ent_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]        push_cnt;
    logic              pop;
    logic [QPTR_W-1:0] wr_plus1;

    // Room for the two results a byte may raise
    assign room     = cnt_reg <= QCNT_W'(QDEPTH - 2);
    assign push_cnt = push ? res.count : 2'd0;
    assign pop      = out_ch.valid && out_ch.ready;
    assign wr_plus1 = wr_reg + QPTR_W'(1);

    assign out_ch.valid   = cnt_reg != '0;
    assign out_ch.payload = ent_reg[rd_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_next  = wr_reg + QPTR_W'(push_cnt);
        rd_next  = pop ? rd_reg + QPTR_W'(1) : rd_reg;
        cnt_next = cnt_reg + QCNT_W'(push_cnt) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Store results in order
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            ent_reg[wr_reg] <= res.first;
        end
        if (push_cnt == 2'd2)
        begin
            ent_reg[wr_plus1] <= res.second;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push_cnt != 2'd0) |-> room)
        else $error("push without room");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_reg - rd_reg) == cnt_reg[QPTR_W-1:0])
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

@@ rtl/core/utf8_stream_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Payload                              Accept
// in_ch    in   byte_value[7:0], string_end          valid && ready
// out_ch   out  code_point[20:0], error, last_result valid && ready
//
// One byte is accepted per cycle while the queue has room; its results enter a
// four-entry result queue and leave it one per cycle while out_ch is ready, so a byte
// raising two results leaves as two transfers. With the queue empty, the first
// result of a byte appears on out_ch the cycle after the byte is accepted; queued
// results delay it further. Input ready drops while the queue holds more than two
// results. Reset clears decoder state and empties the queue.

module utf8_stream_decoder (
    input  logic         clk,
    input  logic         rst_n,
    u8d_stream_if.sink   in_ch,
    u8d_stream_if.source out_ch
);
    import u8d_pkg::*;

    logic      room;
    logic      take;
    res_pair_t res;

    assign in_ch.ready = room;
    assign take        = in_ch.valid && room;

    u8d_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .in_item (in_ch.payload),
        .res     (res)
    );

    u8d_out_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (take),
        .res    (res),
        .room   (room),
        .out_ch (out_ch)
    );

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    import u8d_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 16;

    typedef enum {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PATTERN,
        READY_LONG
    } stall_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    u8d_stream_if #(.payload_t(in_item_t))  in_ch ();
    u8d_stream_if #(.payload_t(out_item_t)) out_ch ();

    utf8_stream_decoder uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Decoder shadow state
    logic [1:0]      cont_left;
    logic [CP_W-1:0] cp_accum;
    logic            skip_trail;

    out_item_t   step_out[$];
    out_item_t   pending_cps[$];
    logic [7:0]  text_bytes[$];

    out_item_t   seen_cp;
    out_item_t   want_cp;

    int          mismatches      = 0;
    int          results_checked = 0;
    int          errors_seen     = 0;
    int          bytes_sent      = 0;
    int          strings_sent    = 0;
    int          cycle_count     = 0;

    bit          gaps_on    = 1'b0;
    int          burst_left = 0;
    stall_mode_t recv_mode  = READY_ALWAYS;
    logic [15:0] stall_pattern = 16'b1011_0111_0011_1101;
    int          stall_left = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_cps.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void add_result(input logic [CP_W-1:0] cp, input logic err);
        out_item_t r;
        r.code_point  = err ? '0 : cp;
        r.error       = err;
        r.last_result = 1'b0;
        step_out.push_back(r);
    endfunction

    // Open a new character at a lead position
    function automatic void start_sequence(input logic [7:0] b, input logic fin);
        skip_trail = 1'b0;
        if ((b & ASCII_MASK) == '0)
        begin
            add_result({14'd0, b[6:0]}, 1'b0);
        end
        else if ((b & LEAD2_MASK) == LEAD2_TAG)
        begin
            cp_accum  = {16'd0, b[4:0]};
            cont_left = 2'd1;
        end
        else if ((b & LEAD3_MASK) == LEAD3_TAG)
        begin
            cp_accum  = {17'd0, b[3:0]};
            cont_left = 2'd2;
        end
        else if ((b & LEAD4_MASK) == LEAD4_TAG)
        begin
            cp_accum  = {18'd0, b[2:0]};
            cont_left = 2'd3;
        end
        else
        begin
            add_result('0, 1'b1);
            skip_trail = 1'b1;
        end
        // string ends before the character is complete
        if (fin && cont_left != 2'd0)
            add_result('0, 1'b1);
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic fin);
        logic      is_cont;
        out_item_t tail;
        is_cont = (b & CONT_MASK) == CONT_TAG;
        if (cont_left != 2'd0)
        begin
            if (is_cont)
            begin
                cp_accum  = {cp_accum[CP_W-7:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0)
                begin
                    add_result(cp_accum, 1'b0);
                    cp_accum   = '0;
                    skip_trail = 1'b1;
                end
                else if (fin)
                begin
                    add_result('0, 1'b1);
                end
            end
            else
            begin
                // broken sequence: report it, then reuse the byte as a lead
                add_result('0, 1'b1);
                cont_left = 2'd0;
                cp_accum  = '0;
                start_sequence(b, fin);
            end
        end
        else if (!(skip_trail && is_cont))
        begin
            start_sequence(b, fin);
        end

        if (fin)
        begin
            cont_left  = 2'd0;
            cp_accum   = '0;
            skip_trail = 1'b0;
        end

        // flag the final result of this byte
        if (step_out.size() > 0)
        begin
            tail = step_out.pop_back();
            tail.last_result = 1'b1;
            step_out.push_back(tail);
        end
        foreach (step_out[i])
            pending_cps.push_back(step_out[i]);
        step_out.delete();
    endfunction

    // Predict on every accepted byte
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            bytes_sent++;
            if (in_ch.payload.string_end)
                strings_sent++;
            decode_byte(in_ch.payload.byte_value, in_ch.payload.string_end);
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic void flag_mismatch(input string what, input out_item_t want,
                                          input out_item_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s: expected cp=%06h error=%0b last=%0b, got cp=%06h error=%0b last=%0b",
                     $time, what, want.code_point, want.error, want.last_result,
                     got.code_point, got.error, got.last_result);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            seen_cp = out_ch.payload;
            if (pending_cps.size() == 0)
            begin
                flag_mismatch("unexpected result", '0, seen_cp);
            end
            else
            begin
                want_cp = pending_cps.pop_front();
                results_checked++;
                if (want_cp.error)
                    errors_seen++;
                if (seen_cp.code_point !== want_cp.code_point
                    || seen_cp.error !== want_cp.error
                    || seen_cp.last_result !== want_cp.last_result)
                    flag_mismatch("result differs", want_cp, seen_cp);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stalls
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        case (recv_mode)
            READY_ALWAYS:
            begin
                out_ch.ready = 1'b1;
            end
            READY_RANDOM:
            begin
                out_ch.ready = ($urandom_range(0, 3) != 0);
            end
            READY_PATTERN:
            begin
                out_ch.ready  = stall_pattern[0];
                stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            end
            default:
            begin
                // occasional long stalls
                if (stall_left > 0)
                begin
                    out_ch.ready = 1'b0;
                    stall_left--;
                end
                else if ($urandom_range(0, 9) == 0)
                begin
                    out_ch.ready = 1'b0;
                    stall_left   = $urandom_range(1, 12);
                end
                else
                begin
                    out_ch.ready = 1'b1;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Drive one item at a falling edge and hold it until accepted
    task automatic send_byte(input logic [7:0] b, input logic fin);
        if (gaps_on && burst_left == 0)
        begin
            in_ch.valid   = 1'b0;
            in_ch.payload = in_item_t'(9'($urandom_range(0, 511)));
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        in_ch.valid   = 1'b1;
        in_ch.payload = {b, fin};
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
    endtask

    // Send the queued text as one string, end flag on the last byte
    task automatic send_text();
        foreach (text_bytes[i])
            send_byte(text_bytes[i], i == text_bytes.size() - 1);
    endtask

    task automatic wait_for_drain();
        in_ch.valid = 1'b0;
        while (pending_cps.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    function automatic logic [7:0] cont_byte();
        logic [5:0] r;
        r = 6'($urandom);
        return {2'b10, r};
    endfunction

    // Append one character, mostly well formed, sometimes damaged
    function automatic void append_char();
        int         pick;
        int         len;
        int         conts;
        logic [7:0] r;
        pick = $urandom_range(0, 99);
        len  = $urandom_range(1, 4);
        r    = 8'($urandom);
        if (pick < 6)
        begin
            text_bytes.push_back(r);
        end
        else if (pick < 10)
        begin
            text_bytes.push_back(LEAD4_MASK | {5'd0, r[2:0]});
        end
        else
        begin
            case (len)
                1: text_bytes.push_back({1'b0, r[6:0]});
                2: text_bytes.push_back({3'b110, r[4:0]});
                3: text_bytes.push_back({4'b1110, r[3:0]});
                default: text_bytes.push_back({5'b11110, r[2:0]});
            endcase
            conts = len - 1;
            // cut the character short
            if (pick < 17 && conts > 0)
                conts = conts - $urandom_range(1, conts);
            // trailing continuation bytes
            if (pick >= 17 && pick < 24)
                conts = conts + $urandom_range(1, 3);
            repeat (conts)
                text_bytes.push_back(cont_byte());
        end
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_valid_characters();
        gaps_on   = 1'b0;
        recv_mode = READY_ALWAYS;
        // ASCII bounds, two-byte, three-byte max, four-byte all ones
        text_bytes = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF,
                       8'hF7, 8'hBF, 8'hBF, 8'hBF};
        send_text();
        wait_for_drain();
    endtask

    task automatic test_invalid_leads();
        gaps_on   = 1'b0;
        recv_mode = READY_ALWAYS;
        // stray continuation, bad lead and swallowed trailers, then a stray after ASCII
        text_bytes = '{8'h80, 8'hFF, 8'h80, 8'hC3, 8'hA9, 8'h80, 8'h41, 8'h80};
        send_text();
        wait_for_drain();
    endtask

    task automatic test_broken_and_truncated();
        gaps_on   = 1'b0;
        recv_mode = READY_RANDOM;
        // broken by ASCII, broken by a bad lead, truncated right at the lead
        text_bytes = '{8'hE2, 8'h82, 8'h41, 8'hF0, 8'hF8, 8'hC3};
        send_text();
        // truncated after one continuation
        text_bytes = '{8'hE2, 8'h82};
        send_text();
        wait_for_drain();
    endtask

    task automatic test_random_strings(input int n_items, input bit with_gaps,
                                       input stall_mode_t mode);
        int sent;
        int n_chars;
        gaps_on    = with_gaps;
        recv_mode  = mode;
        burst_left = 0;
        sent       = 0;
        while (sent < n_items)
        begin
            text_bytes.delete();
            n_chars = $urandom_range(1, 10);
            repeat (n_chars)
                append_char();
            send_text();
            sent += text_bytes.size();
        end
    endtask

    task automatic test_pause_for_drain();
        test_random_strings(25, 1'b1, READY_LONG);
        // hold the sender until every result is back
        wait_for_drain();
        test_random_strings(25, 1'b1, READY_RANDOM);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        out_ch.ready  = 1'b0;
        cont_left     = 2'd0;
        cp_accum      = '0;
        skip_trail    = 1'b0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_valid_characters();
        test_invalid_leads();
        test_broken_and_truncated();
        test_random_strings(300, 1'b0, READY_ALWAYS);
        test_random_strings(400, 1'b1, READY_RANDOM);
        test_pause_for_drain();
        test_random_strings(400, 1'b1, READY_LONG);
        test_random_strings(300, 1'b1, READY_PATTERN);

        wait_for_drain();

        if (pending_cps.size() != 0)
        begin
            $display("%0d expected results never arrived", pending_cps.size());
            mismatches += pending_cps.size();
        end

        $display("Decoded %0d bytes over %0d strings; %0d results checked, %0d of them errors.",
                 bytes_sent, strings_sent, results_checked, errors_seen);
        $display("Mix: 1-4 byte characters, bad leads, broken, truncated and trailing bytes, %s",
                 "with sender gaps and receiver stalls.");
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ utf8_stream_decoder.f @@
rtl/core/u8d_pkg.sv
rtl/core/u8d_stream_if.sv
rtl/core/u8d_decode.sv
rtl/core/u8d_out_queue.sv
rtl/core/utf8_stream_decoder.sv
bench/tb_top.sv
